/* sv/hrsm_pkg.sv */
// Shared types, constants and helpers for the hospital/resident stable matcher.
package hrsm_pkg;

  localparam int unsigned MaxResidentsDef = 32;
  localparam int unsigned MaxHospitalsDef = 32;
  localparam int unsigned SeatSlotsDef    = 8;
  localparam int unsigned ListSlots       = 32;
  localparam int unsigned IdW             = 5;
  localparam int unsigned CfgW            = 6;
  localparam int unsigned CountW          = 11;

  localparam logic CFG_RESIDENTS = 1'b0;
  localparam logic CFG_HOSPITALS = 1'b1;

  typedef enum logic [2:0] {
    ACT_CLEAR    = 3'd0,
    ACT_CHOICE   = 3'd1,
    ACT_RANK     = 3'd2,
    ACT_CAPACITY = 3'd3,
    ACT_RUN      = 3'd4,
    ACT_QUERY    = 3'd5
  } action_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_RUN_INIT,
    ST_PUSH,
    ST_POP,
    ST_CHECK,
    ST_GETH,
    ST_GETRANK,
    ST_SCAN_SEAT,
    ST_SCAN_RANK,
    ST_DECIDE
  } state_e;

  function automatic logic [CountW-1:0] sat_inc(input logic [CountW-1:0] v);
    sat_inc = (&v) ? v : v + CountW'(1);
  endfunction

endpackage

/* sv/hospital_resident_stable_matcher_core.sv */
// Resident-proposing stable matcher with hospital capacities, memory based.
// Usage and timing: an item is taken when start is high and busy is low. A choice, ranking,
// capacity or query item gives its result on done_o in the next cycle and leaves busy low.
// A clear, and the clearing pass that follows reset, walks the rank memory one entry per
// cycle with busy high. A run seeds the free stack with every resident in use that has a
// list, then pops residents and lets each propose down its list; when a hospital is full a
// proposal scans its seated residents for the worst one and then decides. The steps are
// spaced by the single read port of the choice, rank and seat memories. Each result lasts
// exactly one cycle on done_o and cannot be held off by the receiver.
module hospital_resident_stable_matcher_core #(
  parameter int unsigned MAX_RESIDENTS = hrsm_pkg::MaxResidentsDef,
  parameter int unsigned MAX_HOSPITALS = hrsm_pkg::MaxHospitalsDef,
  parameter int unsigned SEAT_SLOTS    = hrsm_pkg::SeatSlotsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [2:0]                    action_i,
  input  logic [hrsm_pkg::IdW-1:0]      resident_i,
  input  logic [hrsm_pkg::IdW-1:0]      hospital_i,
  input  logic [hrsm_pkg::IdW-1:0]      position_i,
  input  logic [3:0]                    seats_i,
  input  logic                          last_entry_i,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [hrsm_pkg::CfgW-1:0]     cfg_wdata_i,
  output logic                          done_o,
  output logic [hrsm_pkg::IdW-1:0]      matched_hospital_o,
  output logic                          is_matched_o,
  output logic [hrsm_pkg::CountW-1:0]   proposal_count_o,
  output logic [hrsm_pkg::CountW-1:0]   rejection_count_o,
  output logic [hrsm_pkg::CountW-1:0]   bump_count_o,
  output logic                          load_error_o
);
  import hrsm_pkg::*;

  localparam int unsigned RW  = (MAX_RESIDENTS > 1) ? $clog2(MAX_RESIDENTS) : 1;
  localparam int unsigned HW  = (MAX_HOSPITALS > 1) ? $clog2(MAX_HOSPITALS) : 1;
  localparam int unsigned SW  = (SEAT_SLOTS > 1) ? $clog2(SEAT_SLOTS) : 1;
  localparam int unsigned CW  = $clog2(SEAT_SLOTS + 1);
  localparam int unsigned TW  = $clog2(MAX_RESIDENTS + 1);
  localparam int unsigned PW  = $clog2(ListSlots);
  localparam int unsigned LW  = $clog2(ListSlots + 1);
  localparam int unsigned KW  = IdW + 1;
  localparam int unsigned RAW = HW + RW;

  // Configuration.
  logic [CfgW-1:0] res_cfg_q, hosp_cfg_q;
  logic [CfgW-1:0] nr_eff, nh_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_cfg_q  <= '0;
      hosp_cfg_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_RESIDENTS) begin
        res_cfg_q <= cfg_wdata_i;
      end else begin
        hosp_cfg_q <= cfg_wdata_i;
      end
    end
  end

  assign nr_eff = (32'(res_cfg_q) > MAX_RESIDENTS) ? CfgW'(MAX_RESIDENTS) : res_cfg_q;
  assign nh_eff = (32'(hosp_cfg_q) > MAX_HOSPITALS) ? CfgW'(MAX_HOSPITALS) : hosp_cfg_q;

  // Control registers.
  state_e            state_q, state_d;
  logic [RAW-1:0]    clr_q, clr_d;
  logic              from_clear_q, from_clear_d;
  logic [CfgW-1:0]   i_q, i_d;
  logic [TW-1:0]     top_q, top_d;
  logic [RW-1:0]     r_q, r_d;
  logic [IdW-1:0]    h_q, h_d;
  logic [CW-1:0]     k_q, k_d;
  logic [SW-1:0]     widx_q, widx_d;
  logic [RW-1:0]     wr_q, wr_d, cr_q, cr_d;
  logic [IdW-1:0]    wrank_q, wrank_d, myrank_q, myrank_d;
  logic [CountW-1:0] prop_q, prop_d, rej_q, rej_d, bmp_q, bmp_d;
  logic              done_q, done_d, im_q, im_d, err_q, err_d;
  logic [IdW-1:0]    mh_q, mh_d;

  // Per-resident and per-hospital flop arrays.
  logic [LW-1:0]          len_q [MAX_RESIDENTS];
  logic [LW-1:0]          nc_q  [MAX_RESIDENTS];
  logic [MAX_RESIDENTS-1:0] matched_q;
  logic [IdW-1:0]         match_q [MAX_RESIDENTS];
  logic [RW-1:0]          stack_q [MAX_RESIDENTS];
  logic [CW-1:0]          cap_q   [MAX_HOSPITALS];
  logic [CW-1:0]          taken_q [MAX_HOSPITALS];

  // Memories.
  logic [IdW-1:0] choice_mem [2**(RW+PW)];
  logic [KW-1:0]  rank_mem   [2**RAW];
  logic [RW-1:0]  seat_mem   [2**(HW+SW)];

  logic [RW+PW-1:0] choice_raddr;
  logic [IdW-1:0]   choice_rd_q;
  logic             choice_we;
  logic [RAW-1:0]   rank_raddr, rank_waddr;
  logic [KW-1:0]    rank_rd_q, rank_wdata;
  logic             rank_we;
  logic [HW+SW-1:0] seat_raddr, seat_waddr;
  logic [RW-1:0]    seat_rd_q;
  logic             seat_we;

  // Array update strobes.
  logic             clear_lists, run_init, nc_inc, seat_fill, bump_en, push_en;
  logic [RW-1:0]    push_val;

  logic [RW-1:0]    ridx_in, len_addr;
  logic [HW-1:0]    hidx_in, hidx;
  logic [LW-1:0]    len_rd, nc_rd;
  logic [CW-1:0]    cap_rd, n_rd, cap_in;
  logic             res_ok, hosp_ok, accept;

  assign ridx_in  = RW'(resident_i);
  assign hidx_in  = HW'(hospital_i);
  assign hidx     = HW'(h_q);
  assign res_ok   = {1'b0, resident_i} < nr_eff;
  assign hosp_ok  = {1'b0, hospital_i} < nh_eff;
  assign accept   = start && !busy;
  assign busy     = (state_q != ST_IDLE);
  assign cap_in   = (32'(seats_i) > SEAT_SLOTS) ? CW'(SEAT_SLOTS) : CW'(seats_i);

  always_comb begin
    case (state_q)
      ST_PUSH:   len_addr = RW'(i_q);
      ST_DECIDE: len_addr = wr_q;
      default:   len_addr = r_q;
    endcase
  end

  assign len_rd = len_q[len_addr];
  assign nc_rd  = nc_q[len_addr];
  assign cap_rd = cap_q[hidx];
  assign n_rd   = taken_q[hidx];

  assign choice_raddr = {r_q, PW'(nc_rd)};

  always_comb begin
    case (state_q)
      ST_GETH:      rank_raddr = {HW'(choice_rd_q), r_q};
      ST_SCAN_SEAT: rank_raddr = {hidx, seat_rd_q};
      default:      rank_raddr = {hidx, r_q};
    endcase
  end

  assign seat_raddr = (state_q == ST_SCAN_RANK) ? {hidx, SW'(k_q + CW'(1))} : {hidx, SW'(0)};
  assign seat_waddr = (state_q == ST_GETRANK) ? {hidx, SW'(n_rd)} : {hidx, widx_q};

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    from_clear_d = from_clear_q;
    i_d          = i_q;
    top_d        = top_q;
    r_d          = r_q;
    h_d          = h_q;
    k_d          = k_q;
    widx_d       = widx_q;
    wr_d         = wr_q;
    cr_d         = cr_q;
    wrank_d      = wrank_q;
    myrank_d     = myrank_q;
    prop_d       = prop_q;
    rej_d        = rej_q;
    bmp_d        = bmp_q;
    done_d       = 1'b0;
    im_d         = 1'b0;
    err_d        = 1'b0;
    mh_d         = '0;
    choice_we    = 1'b0;
    rank_we      = 1'b0;
    rank_waddr   = {hidx_in, ridx_in};
    rank_wdata   = {1'b1, position_i};
    seat_we      = 1'b0;
    clear_lists  = 1'b0;
    run_init     = 1'b0;
    nc_inc       = 1'b0;
    seat_fill    = 1'b0;
    bump_en      = 1'b0;
    push_en      = 1'b0;
    push_val     = wr_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (action_i)
            ACT_CLEAR: begin
              clear_lists  = 1'b1;
              clr_d        = '0;
              from_clear_d = 1'b1;
              state_d      = ST_SWEEP;
            end
            ACT_CHOICE: begin
              done_d    = 1'b1;
              err_d     = !(res_ok && hosp_ok);
              choice_we = res_ok && hosp_ok;
            end
            ACT_RANK: begin
              done_d  = 1'b1;
              err_d   = !(res_ok && hosp_ok);
              rank_we = res_ok && hosp_ok;
            end
            ACT_CAPACITY: begin
              done_d = 1'b1;
              err_d  = !hosp_ok;
            end
            ACT_RUN: begin
              prop_d  = '0;
              rej_d   = '0;
              bmp_d   = '0;
              state_d = ST_RUN_INIT;
            end
            ACT_QUERY: begin
              done_d = 1'b1;
              im_d   = (32'(resident_i) < MAX_RESIDENTS) && matched_q[ridx_in];
              mh_d   = im_d ? match_q[ridx_in] : '0;
            end
            default: ;
          endcase
        end
      end
      ST_SWEEP: begin
        rank_we    = 1'b1;
        rank_waddr = clr_q;
        rank_wdata = '0;
        clr_d      = clr_q + RAW'(1);
        if (&clr_q) begin
          done_d       = from_clear_q;
          from_clear_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end
      ST_RUN_INIT: begin
        if (nr_eff == '0) begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          run_init = 1'b1;
          top_d    = '0;
          i_d      = '0;
          state_d  = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (len_rd != '0) begin
          push_en  = 1'b1;
          push_val = RW'(i_q);
          top_d    = top_q + TW'(1);
        end
        i_d = i_q + CfgW'(1);
        if (i_q + CfgW'(1) == nr_eff) begin
          state_d = ST_POP;
        end
      end
      ST_POP: begin
        if (top_q == '0) begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          r_d     = stack_q[RW'(top_q - TW'(1))];
          top_d   = top_q - TW'(1);
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (matched_q[r_q] || nc_rd >= len_rd) begin
          state_d = ST_POP;
        end else begin
          nc_inc  = 1'b1;
          prop_d  = sat_inc(prop_q);
          state_d = ST_GETH;
        end
      end
      ST_GETH: begin
        h_d = choice_rd_q;
        if ({1'b0, choice_rd_q} >= nh_eff) begin
          rej_d   = sat_inc(rej_q);
          state_d = ST_CHECK;
        end else begin
          state_d = ST_GETRANK;
        end
      end
      ST_GETRANK: begin
        if (!rank_rd_q[IdW] || cap_rd == '0) begin
          rej_d   = sat_inc(rej_q);
          state_d = ST_CHECK;
        end else if (n_rd < cap_rd) begin
          seat_we   = 1'b1;
          seat_fill = 1'b1;
          state_d   = ST_POP;
        end else begin
          myrank_d = rank_rd_q[IdW-1:0];
          k_d      = '0;
          state_d  = ST_SCAN_SEAT;
        end
      end
      ST_SCAN_SEAT: begin
        cr_d    = seat_rd_q;
        state_d = ST_SCAN_RANK;
      end
      ST_SCAN_RANK: begin
        // The first seat seeds the search; later seats replace it only when strictly worse.
        if (k_q == '0 || rank_rd_q[IdW-1:0] > wrank_q) begin
          wrank_d = rank_rd_q[IdW-1:0];
          wr_d    = cr_q;
          widx_d  = SW'(k_q);
        end
        k_d = k_q + CW'(1);
        state_d = (k_q + CW'(1) < n_rd) ? ST_SCAN_SEAT : ST_DECIDE;
      end
      ST_DECIDE: begin
        if (myrank_q < wrank_q) begin
          bmp_d   = sat_inc(bmp_q);
          seat_we = 1'b1;
          bump_en = 1'b1;
          if (nc_rd < len_rd && 32'(top_q) < MAX_RESIDENTS) begin
            push_en = 1'b1;
            top_d   = top_q + TW'(1);
          end
          state_d = ST_POP;
        end else begin
          rej_d   = sat_inc(rej_q);
          state_d = ST_CHECK;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_SWEEP;
      clr_q        <= '0;
      from_clear_q <= 1'b0;
      i_q          <= '0;
      top_q        <= '0;
      prop_q       <= '0;
      rej_q        <= '0;
      bmp_q        <= '0;
      done_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      from_clear_q <= from_clear_d;
      i_q          <= i_d;
      top_q        <= top_d;
      prop_q       <= prop_d;
      rej_q        <= rej_d;
      bmp_q        <= bmp_d;
      done_q       <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q      <= r_d;
    h_q      <= h_d;
    k_q      <= k_d;
    widx_q   <= widx_d;
    wr_q     <= wr_d;
    cr_q     <= cr_d;
    wrank_q  <= wrank_d;
    myrank_q <= myrank_d;
    mh_q     <= mh_d;
    im_q     <= im_d;
    err_q    <= err_d;
  end

  // Resident state arrays.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      matched_q <= '0;
      for (int j = 0; j < MAX_RESIDENTS; j++) begin
        len_q[j]   <= '0;
        nc_q[j]    <= '0;
        match_q[j] <= '0;
      end
    end else begin
      if (clear_lists) begin
        for (int j = 0; j < MAX_RESIDENTS; j++) begin
          len_q[j] <= '0;
        end
      end
      if (choice_we && last_entry_i) begin
        len_q[ridx_in] <= LW'(position_i) + LW'(1);
      end
      if (run_init) begin
        matched_q <= '0;
        for (int j = 0; j < MAX_RESIDENTS; j++) begin
          nc_q[j]    <= '0;
          match_q[j] <= '0;
        end
      end
      if (nc_inc) begin
        nc_q[r_q] <= nc_rd + LW'(1);
      end
      // A bump frees the worst seat and hands it to the proposer in one update.
      if (bump_en) begin
        matched_q <= (matched_q & ~(MAX_RESIDENTS'(1) << wr_q)) | (MAX_RESIDENTS'(1) << r_q);
      end
      if (seat_fill) begin
        matched_q[r_q] <= 1'b1;
      end
      if (seat_fill || bump_en) begin
        match_q[r_q] <= h_q;
      end
    end
  end

  // Hospital state arrays.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < MAX_HOSPITALS; j++) begin
        cap_q[j]   <= '0;
        taken_q[j] <= '0;
      end
    end else begin
      if (clear_lists) begin
        for (int j = 0; j < MAX_HOSPITALS; j++) begin
          cap_q[j] <= '0;
        end
      end
      if (accept && action_i == ACT_CAPACITY && hosp_ok) begin
        cap_q[hidx_in] <= cap_in;
      end
      if (run_init) begin
        for (int j = 0; j < MAX_HOSPITALS; j++) begin
          taken_q[j] <= '0;
        end
      end
      if (seat_fill) begin
        taken_q[hidx] <= n_rd + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_en) begin
      stack_q[RW'(top_q)] <= push_val;
    end
  end

  // Memories: one write and one registered read per cycle. Accesses of one item are spaced
  // by the state sequence, so a read never meets a write to the same entry in flight.
  always_ff @(posedge clk_i) begin
    if (choice_we) begin
      choice_mem[{ridx_in, position_i}] <= hospital_i;
    end
    choice_rd_q <= choice_mem[choice_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (rank_we) begin
      rank_mem[rank_waddr] <= rank_wdata;
    end
    rank_rd_q <= rank_mem[rank_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (seat_we) begin
      seat_mem[seat_waddr] <= r_q;
    end
    seat_rd_q <= seat_mem[seat_raddr];
  end

  assign done_o             = done_q;
  assign matched_hospital_o = mh_q;
  assign is_matched_o       = im_q;
  assign load_error_o       = err_q;
  assign proposal_count_o   = prop_q;
  assign rejection_count_o  = rej_q;
  assign bump_count_o       = bmp_q;

  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(top_q) <= MAX_RESIDENTS)
    else $error("free stack overflow");

  a_worst_seated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DECIDE) |-> (CW'(widx_q) < n_rd))
    else $error("worst seat index beyond filled seats");

  a_done_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(state_q) != ST_IDLE || $past(accept)))
    else $error("result without a transfer or finished operation");

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the hospital/resident stable matcher core.
`timescale 1ns / 100ps

module tb_top;
  import hrsm_pkg::*;

  localparam logic [2:0] ACT_SPARE6 = 3'd6;
  localparam logic [2:0] ACT_SPARE7 = 3'd7;
  localparam int unsigned NR = 32;
  localparam int unsigned NH = 32;
  localparam int unsigned SLOTS = 8;
  localparam int unsigned COUNT_CAP = 2047;
  localparam int unsigned CYCLE_LIMIT = 4000000;

  typedef struct packed {
    logic [IdW-1:0]    hosp;
    logic              matched;
    logic [CountW-1:0] proposals;
    logic [CountW-1:0] rejections;
    logic [CountW-1:0] bumps;
    logic              load_err;
  } outcome_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [2:0] action_i = '0;
  logic [IdW-1:0] resident_i = '0;
  logic [IdW-1:0] hospital_i = '0;
  logic [IdW-1:0] position_i = '0;
  logic [3:0] seats_i = '0;
  logic last_entry_i = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = 1'b0;
  logic [CfgW-1:0] cfg_wdata_i = '0;
  logic done_o;
  logic [IdW-1:0] matched_hospital_o;
  logic is_matched_o;
  logic [CountW-1:0] proposal_count_o;
  logic [CountW-1:0] rejection_count_o;
  logic [CountW-1:0] bump_count_o;
  logic load_error_o;

  hospital_resident_stable_matcher_core uut (
    .clk_i, .rst_ni, .start, .busy, .action_i, .resident_i, .hospital_i, .position_i,
    .seats_i, .last_entry_i, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i, .done_o,
    .matched_hospital_o, .is_matched_o, .proposal_count_o, .rejection_count_o,
    .bump_count_o, .load_error_o
  );

  // Predictor state.
  int unsigned residents_cfg, hospitals_cfg;
  logic [IdW-1:0] choice_ref [NR][32];
  int unsigned pref_len [NR];
  int unsigned hosp_rank [NH][NR];
  bit ranked [NH][NR];
  int unsigned seat_cap [NH];
  logic [IdW-1:0] seated [NH][SLOTS];
  int unsigned seats_used [NH];
  bit holds_seat [NR];
  logic [IdW-1:0] assigned_hosp [NR];
  int unsigned next_pick [NR];
  int unsigned waiting [NR];
  int unsigned waiting_top;
  int unsigned run_count [3];

  // Generator bookkeeping: list places ever written, so no list covers an unwritten place.
  bit place_written [NR][32];

  outcome_t pending_results[$];
  int unsigned errors = 0;
  int unsigned items_sent = 0;
  int unsigned idle_odds = 4;
  longint unsigned cycles = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic int unsigned eff(int unsigned v, int unsigned lim);
    return (v > lim) ? lim : v;
  endfunction

  function automatic void count_up(int k);
    if (run_count[k] < COUNT_CAP) run_count[k]++;
  endfunction

  function automatic void queue_free(int unsigned r);
    if (waiting_top < NR) begin
      waiting[waiting_top] = r;
      waiting_top++;
    end
  endfunction

  function automatic void match_all();
    int unsigned nr, nh, r, h, n, widx, wr, wrank, k, cr;
    nr = eff(residents_cfg, NR);
    nh = eff(hospitals_cfg, NH);
    run_count = '{0, 0, 0};
    if (nr == 0) return;
    for (int i = 0; i < NR; i++) begin
      holds_seat[i] = 1'b0;
      assigned_hosp[i] = '0;
      next_pick[i] = 0;
    end
    for (int i = 0; i < NH; i++) seats_used[i] = 0;
    waiting_top = 0;
    for (int i = 0; i < nr; i++) if (pref_len[i] > 0) queue_free(i);
    while (waiting_top > 0) begin
      waiting_top--;
      r = waiting[waiting_top];
      while (!holds_seat[r] && next_pick[r] < pref_len[r] && next_pick[r] < 32) begin
        h = 32'(choice_ref[r][next_pick[r]]);
        next_pick[r]++;
        count_up(0);
        if (h >= nh || !ranked[h][r] || seat_cap[h] == 0) begin
          count_up(1);
          continue;
        end
        n = seats_used[h];
        if (n < seat_cap[h] && n < SLOTS) begin
          seated[h][n] = IdW'(r);
          seats_used[h] = n + 1;
          holds_seat[r] = 1'b1;
          assigned_hosp[r] = IdW'(h);
          break;
        end
        widx = 0;
        wr = 32'(seated[h][0]);
        wrank = hosp_rank[h][wr];
        for (k = 1; k < n && k < SLOTS; k++) begin
          cr = 32'(seated[h][k]);
          if (hosp_rank[h][cr] > wrank) begin
            wrank = hosp_rank[h][cr];
            wr = cr;
            widx = k;
          end
        end
        if (hosp_rank[h][r] < wrank) begin
          count_up(2);
          holds_seat[wr] = 1'b0;
          assigned_hosp[wr] = '0;
          seated[h][widx] = IdW'(r);
          holds_seat[r] = 1'b1;
          assigned_hosp[r] = IdW'(h);
          if (next_pick[wr] < pref_len[wr]) queue_free(wr);
          break;
        end
        count_up(1);
      end
    end
  endfunction

  // Applies one item to the predictor; returns 0 for codes the block ignores.
  function automatic bit predict_outcome(input logic [2:0] act, input int unsigned r,
                                         input int unsigned h, input int unsigned pos,
                                         input int unsigned seats, input bit last,
                                         output outcome_t o);
    bit bad;
    o = '0;
    bad = (r >= eff(residents_cfg, NR)) || (h >= eff(hospitals_cfg, NH));
    case (act)
      ACT_CLEAR: begin
        for (int i = 0; i < NR; i++) pref_len[i] = 0;
        for (int i = 0; i < NH; i++) begin
          seat_cap[i] = 0;
          for (int j = 0; j < NR; j++) begin
            ranked[i][j] = 1'b0;
            hosp_rank[i][j] = 0;
          end
        end
      end
      ACT_CHOICE: begin
        if (bad) o.load_err = 1'b1;
        else begin
          choice_ref[r][pos] = IdW'(h);
          if (last) pref_len[r] = pos + 1;
        end
      end
      ACT_RANK: begin
        if (bad) o.load_err = 1'b1;
        else begin
          hosp_rank[h][r] = pos;
          ranked[h][r] = 1'b1;
        end
      end
      ACT_CAPACITY: begin
        if (h >= eff(hospitals_cfg, NH)) o.load_err = 1'b1;
        else seat_cap[h] = (seats > SLOTS) ? SLOTS : seats;
      end
      ACT_RUN: match_all();
      ACT_QUERY: begin
        if (holds_seat[r]) begin
          o.matched = 1'b1;
          o.hosp = assigned_hosp[r];
        end
      end
      default: return 1'b0;
    endcase
    o.proposals = CountW'(run_count[0]);
    o.rejections = CountW'(run_count[1]);
    o.bumps = CountW'(run_count[2]);
    return 1'b1;
  endfunction

  task automatic send_item(input logic [2:0] act, input int unsigned r, input int unsigned h,
                           input int unsigned pos, input int unsigned seats, input bit last);
    int unsigned gap;
    outcome_t o;
    gap = 0;
    if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0)
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    // Keep list places that a later last flag could expose on record.
    if (act == ACT_CHOICE && r < eff(residents_cfg, NR) && h < eff(hospitals_cfg, NH))
      place_written[r][pos] = 1'b1;
    action_i <= act;
    resident_i <= IdW'(r);
    hospital_i <= IdW'(h);
    position_i <= IdW'(pos);
    seats_i <= 4'(seats);
    last_entry_i <= last;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    if (predict_outcome(act, r, h, pos, seats, last, o)) begin
      pending_results.push_back(o);
      items_sent++;
    end
  endtask

  // Lets the block finish and go quiet; configuration is written only after this.
  task automatic wait_quiet();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic set_sizes(input int unsigned nres, input int unsigned nhosp);
    wait_quiet();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_RESIDENTS;
    cfg_wdata_i <= CfgW'(nres);
    @(posedge clk_i);
    residents_cfg = nres;
    cfg_idx_i <= CFG_HOSPITALS;
    cfg_wdata_i <= CfgW'(nhosp);
    @(posedge clk_i);
    hospitals_cfg = nhosp;
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_list(input int unsigned r, input int unsigned h0, input int unsigned n,
                           input int unsigned hbase, input int unsigned hspan);
    for (int unsigned p = 0; p < n; p++)
      send_item(ACT_CHOICE, r, (p == 0) ? h0 : hbase + $urandom_range(0, hspan - 1), p, 0,
                p == n - 1);
  endtask

  task automatic test_directed();
    set_sizes(4, 3);
    send_item(ACT_CAPACITY, 0, 0, 0, 1, 0);
    send_item(ACT_CAPACITY, 0, 1, 0, 15, 0);
    send_item(ACT_CAPACITY, 0, 2, 0, 0, 0);
    send_item(ACT_RANK, 0, 0, 5, 0, 0);
    send_item(ACT_RANK, 1, 0, 2, 0, 0);
    send_item(ACT_RANK, 2, 0, 9, 0, 0);
    send_item(ACT_RANK, 0, 1, 0, 0, 0);
    send_item(ACT_RANK, 3, 1, 31, 0, 0);
    send_item(ACT_RANK, 1, 2, 1, 0, 0);
    load_list(0, 0, 1, 0, 1);
    send_item(ACT_CHOICE, 0, 1, 1, 0, 1);
    send_item(ACT_CHOICE, 1, 0, 0, 0, 1);
    send_item(ACT_CHOICE, 2, 0, 0, 0, 0);
    send_item(ACT_CHOICE, 2, 2, 1, 0, 1);
    send_item(ACT_CHOICE, 3, 1, 0, 0, 1);
    // Out-of-range ids on every kind of load.
    send_item(ACT_CHOICE, 31, 0, 31, 0, 1);
    send_item(ACT_RANK, 0, 31, 31, 0, 0);
    send_item(ACT_CAPACITY, 0, 3, 0, 8, 0);
    send_item(ACT_RUN, 0, 0, 0, 0, 0);
    for (int unsigned r = 0; r < 4; r++) send_item(ACT_QUERY, r, 0, 0, 0, 0);
    send_item(ACT_SPARE6, 31, 31, 31, 15, 1);
    send_item(ACT_SPARE7, 0, 0, 0, 0, 0);
    send_item(ACT_QUERY, 31, 0, 0, 0, 0);
    // Hospitals dropped from use leave stale entries in the lists.
    set_sizes(4, 1);
    send_item(ACT_RUN, 0, 0, 0, 0, 0);
    send_item(ACT_QUERY, 2, 0, 0, 0, 0);
    set_sizes(0, 0);
    send_item(ACT_RUN, 0, 0, 0, 0, 0);
    send_item(ACT_QUERY, 0, 0, 0, 0, 0);
    set_sizes(63, 63);
    send_item(ACT_CLEAR, 0, 0, 0, 0, 0);
    send_item(ACT_RUN, 0, 0, 0, 0, 0);
  endtask

  task automatic send_noise(input int unsigned rbase, input int unsigned hbase);
    logic [2:0] act;
    int unsigned r, h, pos;
    bit last;
    act = 3'($urandom_range(0, 7));
    if (act == ACT_CLEAR && $urandom_range(0, 3) != 0) act = ACT_QUERY;
    r = ($urandom_range(0, 1) != 0) ? rbase + $urandom_range(0, 3) : $urandom_range(0, 31);
    h = ($urandom_range(0, 1) != 0) ? hbase + $urandom_range(0, 3) : $urandom_range(0, 31);
    r = r % 32;
    h = h % 32;
    pos = $urandom_range(0, 31);
    last = 1'($urandom_range(0, 1));
    if (act == ACT_CHOICE) begin
      // A last flag may only close a list whose places are all written.
      if (!place_written[r][pos]) place_written[r][pos] = (r < eff(residents_cfg, NR) &&
                                                          h < eff(hospitals_cfg, NH));
      for (int unsigned p = 0; p < pos; p++) if (!place_written[r][p]) last = 1'b0;
    end
    send_item(act, r, h, pos, $urandom_range(0, 15), last);
  endtask

  task automatic test_random_problems();
    int unsigned nres, nhosp, rb, hb, mode;
    while (items_sent < 120) begin
      mode = $urandom_range(0, 9);
      if (mode == 0) set_sizes($urandom_range(32, 63), $urandom_range(32, 63));
      else if (mode == 1) set_sizes(32, 32);
      else if (mode == 2) set_sizes($urandom_range(0, 2), $urandom_range(0, 2));
      else set_sizes($urandom_range(2, 6), $urandom_range(2, 5));
      idle_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 6);
      nres = eff(residents_cfg, NR);
      nhosp = eff(hospitals_cfg, NH);
      rb = (nres > 6) ? $urandom_range(0, nres - 6) : 0;
      hb = (nhosp > 5) ? $urandom_range(0, nhosp - 5) : 0;
      if (nres > 6) nres = 6;
      if (nhosp > 5) nhosp = 5;
      if ($urandom_range(0, 2) == 0) send_item(ACT_CLEAR, 0, 0, 0, 0, 0);
      if (nhosp != 0 && nres != 0) begin
        for (int unsigned h = 0; h < nhosp; h++)
          send_item(ACT_CAPACITY, 0, hb + h,
                    0, ($urandom_range(0, 5) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 2),
                    0);
        for (int unsigned h = 0; h < nhosp; h++)
          for (int unsigned r = 0; r < nres; r++)
            if ($urandom_range(0, 5) != 0) send_item(ACT_RANK, rb + r, hb + h,
                                                     $urandom_range(0, 31), 0, 0);
        for (int unsigned r = 0; r < nres; r++)
          load_list(rb + r, hb + $urandom_range(0, nhosp - 1), $urandom_range(1, 4), hb, nhosp);
      end
      repeat ($urandom_range(0, 3)) send_noise(rb, hb);
      send_item(ACT_RUN, 0, 0, 0, 0, 0);
      for (int unsigned r = 0; r < nres; r++) send_item(ACT_QUERY, rb + r, 0, 0, 0, 0);
      repeat ($urandom_range(0, 2)) send_noise(rb, hb);
    end
  endtask

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got hospital %0d counts %0d/%0d/%0d",
                 $realtime, matched_hospital_o, proposal_count_o, rejection_count_o,
                 bump_count_o);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("matched_hospital", 32'(want.hosp), 32'(matched_hospital_o));
        check_field("is_matched", 32'(want.matched), 32'(is_matched_o));
        check_field("proposal_count", 32'(want.proposals), 32'(proposal_count_o));
        check_field("rejection_count", 32'(want.rejections), 32'(rejection_count_o));
        check_field("bump_count", 32'(want.bumps), 32'(bump_count_o));
        check_field("load_error", 32'(want.load_err), 32'(load_error_o));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    residents_cfg = 0;
    hospitals_cfg = 0;
    waiting_top = 0;
    for (int i = 0; i < NR; i++) begin
      pref_len[i] = 0;
      holds_seat[i] = 1'b0;
      assigned_hosp[i] = '0;
      next_pick[i] = 0;
      for (int j = 0; j < 32; j++) place_written[i][j] = 1'b0;
    end
    for (int i = 0; i < NH; i++) begin
      seat_cap[i] = 0;
      seats_used[i] = 0;
      for (int j = 0; j < NR; j++) begin
        ranked[i][j] = 1'b0;
        hosp_rank[i][j] = 0;
      end
    end
    run_count = '{0, 0, 0};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_problems();
    wait_quiet();
    repeat (50) @(posedge clk_i);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* hospital_resident_stable_matcher_core.f */
sv/hrsm_pkg.sv
sv/hospital_resident_stable_matcher_core.sv
tb/tb_top.sv
